FILE: sv/qoi_rgb_chunk_decoder_core_defines.svh
// Assertion macros used by the controller of the QOI RGB chunk decoder RTL.
`ifndef QOI_RGB_CHUNK_DECODER_CORE_DEFINES_SVH
`define QOI_RGB_CHUNK_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QRCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define QRCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/qrcd_pkg.sv
// Types, constants and helper functions of the QOI RGB chunk decoder.
`default_nettype none
package qrcd_pkg;

	// Two-bit chunk tags in the top bits of an opcode byte.
	localparam logic [1:0] TAG_INDEX = 2'b00;
	localparam logic [1:0] TAG_DIFF  = 2'b01;
	localparam logic [1:0] TAG_LUMA  = 2'b10;
	localparam logic [1:0] TAG_RUN   = 2'b11;

	// Full-byte opcodes that share the run tag.
	localparam logic [7:0] OP_RGB  = 8'hFE;
	localparam logic [7:0] OP_RGBA = 8'hFF;

	// Bytes still awaited after the RGB opcode.
	localparam logic [1:0] RGB_DATA_BYTES = 2'd3;

	localparam int unsigned INDEX_DEPTH = 64;
	localparam int unsigned INDEX_AW    = 6;

	// Alpha is always 255, so its hash term 255 * 11 reduces to this bias.
	localparam logic [INDEX_AW-1:0] HASH_BIAS = INDEX_AW'((255 * 11) % INDEX_DEPTH);

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} qrcd_pixel_t;

	typedef enum logic [1:0] {
		ST_ACCEPT,
		ST_INDEX,
		ST_RUN
	} qrcd_state_t;

	// What the byte at the input will do when it is taken.
	typedef enum logic [1:0] {
		KIND_SINGLE,
		KIND_INDEX,
		KIND_RUN
	} qrcd_kind_t;

	typedef struct packed {
		logic take;
		logic index_load;
		logic run_step;
	} qrcd_cmd_t;

	typedef struct packed {
		qrcd_kind_t kind;
		logic       out_free;
		logic       run_done;
	} qrcd_sts_t;

	function automatic logic [INDEX_AW-1:0] hash_of(input qrcd_pixel_t px);
		logic [INDEX_AW-1:0] r6;
		logic [INDEX_AW-1:0] g6;
		logic [INDEX_AW-1:0] b6;
		r6 = px.r[INDEX_AW-1:0];
		g6 = px.g[INDEX_AW-1:0];
		b6 = px.b[INDEX_AW-1:0];
		return INDEX_AW'(r6 * 3) + INDEX_AW'(g6 * 5) + INDEX_AW'(b6 * 7) + HASH_BIAS;
	endfunction

endpackage
`default_nettype wire

FILE: sv/qrcd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module qrcd_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: sv/qrcd_ctrl.sv
// Controller state machine of the QOI RGB chunk decoder.
`default_nettype none
`include "qoi_rgb_chunk_decoder_core_defines.svh"
module qrcd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire qrcd_pkg::qrcd_sts_t sts,
	output      qrcd_pkg::qrcd_cmd_t cmd
);
	import qrcd_pkg::*;

	qrcd_state_t state_q;
	qrcd_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_ACCEPT: begin
				if (in_valid && sts.out_free) begin
					unique case (sts.kind)
						KIND_INDEX:  state_n = ST_INDEX;
						KIND_RUN:    state_n = ST_RUN;
						default:     state_n = ST_ACCEPT;
					endcase
				end
			end
			ST_INDEX: state_n = ST_ACCEPT;
			ST_RUN: begin
				if (sts.out_free && sts.run_done) begin
					state_n = ST_ACCEPT;
				end
			end
			default: state_n = ST_ACCEPT;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd.take       = 1'b0;
		cmd.index_load = 1'b0;
		cmd.run_step   = 1'b0;
		unique case (state_q)
			ST_ACCEPT: begin
				in_ready = sts.out_free;
				cmd.take = in_valid && sts.out_free;
			end
			ST_INDEX: cmd.index_load = 1'b1;
			ST_RUN:   cmd.run_step = sts.out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	`QRCD_ASSERT_NEXT(a_index_then_load, cmd.take && sts.kind == KIND_INDEX, cmd.index_load, "index byte did not load its table entry next cycle")
	`QRCD_ASSERT_NEXT(a_index_one_cycle, cmd.index_load, !cmd.index_load, "index lookup held longer than one cycle")
	`QRCD_ASSERT_NOW(a_step_needs_room, cmd.run_step || cmd.index_load, sts.out_free, "pixel produced while the output register is occupied")
	`QRCD_ASSERT_NOW(a_no_take_busy, cmd.run_step || cmd.index_load, !in_ready, "input offered while a chunk is still in work")

endmodule
`default_nettype wire

FILE: sv/qrcd_dp.sv
// Datapath of the QOI RGB chunk decoder: chunk decode, index table, output register.
`default_nettype none
module qrcd_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [7:0]          chunk_byte,
	input  wire logic                image_start,
	input  wire qrcd_pkg::qrcd_cmd_t cmd,
	output      qrcd_pkg::qrcd_sts_t sts,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      qrcd_pkg::qrcd_pixel_t out_pixel,
	output      logic                out_last,
	output      logic                out_bad
);
	import qrcd_pkg::*;

	logic [1:0]          pend_q;
	logic                rgb_q;
	logic [15:0]         held_q;
	qrcd_pixel_t         prev_q;
	logic [INDEX_DEPTH-1:0] valid_q;
	logic                hit_q;
	logic [5:0]          count_q;
	logic                out_valid_q;
	qrcd_pixel_t         out_pixel_q;
	logic                out_last_q;
	logic                out_bad_q;

	qrcd_pixel_t         eff_prev;
	logic [1:0]          eff_pend;
	logic [1:0]          tag;
	qrcd_kind_t          kind;
	logic                emit;
	logic                emit_last;
	logic                emit_bad;
	logic                wr;
	qrcd_pixel_t         px;
	logic [1:0]          pend_n;
	logic                rgb_n;
	logic [15:0]         held_n;
	logic [7:0]          dg;
	logic [INDEX_AW-1:0] wr_addr;
	logic                rd_en;
	logic [23:0]         rd_data;
	qrcd_pixel_t         index_px;

	// A new image drops the partial chunk and the previous pixel first.
	assign eff_prev = image_start ? '0 : prev_q;
	assign eff_pend = image_start ? 2'd0 : pend_q;
	assign tag      = chunk_byte[7:6];
	assign dg       = {2'b00, held_q[5:0]} - 8'd32;

	always_comb begin
		emit      = 1'b0;
		emit_last = 1'b1;
		emit_bad  = 1'b0;
		wr        = 1'b0;
		px        = eff_prev;
		pend_n    = eff_pend;
		rgb_n     = image_start ? 1'b0 : rgb_q;
		held_n    = image_start ? 16'd0 : held_q;
		kind      = KIND_SINGLE;
		priority if (eff_pend != 2'd0) begin
			if (rgb_n) begin
				if (eff_pend > 2'd1) begin
					held_n = {held_q[7:0], chunk_byte};
					pend_n = eff_pend - 2'd1;
				end else begin
					px     = '{r: held_q[15:8], g: held_q[7:0], b: chunk_byte};
					emit   = 1'b1;
					wr     = 1'b1;
					pend_n = 2'd0;
				end
			end else begin
				px.r   = eff_prev.r + dg + {4'b0000, chunk_byte[7:4]} - 8'd8;
				px.g   = eff_prev.g + dg;
				px.b   = eff_prev.b + dg + {4'b0000, chunk_byte[3:0]} - 8'd8;
				emit   = 1'b1;
				wr     = 1'b1;
				pend_n = 2'd0;
			end
		end else if (tag == TAG_INDEX) begin
			kind = KIND_INDEX;
		end else if (tag == TAG_DIFF) begin
			px.r = eff_prev.r + {6'b0, chunk_byte[5:4]} - 8'd2;
			px.g = eff_prev.g + {6'b0, chunk_byte[3:2]} - 8'd2;
			px.b = eff_prev.b + {6'b0, chunk_byte[1:0]} - 8'd2;
			emit = 1'b1;
			wr   = 1'b1;
		end else if (tag == TAG_LUMA) begin
			held_n = {8'h00, chunk_byte};
			rgb_n  = 1'b0;
			pend_n = 2'd1;
		end else if (chunk_byte == OP_RGB) begin
			held_n = 16'd0;
			rgb_n  = 1'b1;
			pend_n = RGB_DATA_BYTES;
		end else if (chunk_byte == OP_RGBA) begin
			px       = '0;
			emit     = 1'b1;
			emit_bad = 1'b1;
		end else begin
			// Run: the first pixel goes out now, the rest from the run counter.
			emit      = 1'b1;
			emit_last = (chunk_byte[5:0] == 6'd0);
			if (chunk_byte[5:0] != 6'd0) begin
				kind = KIND_RUN;
			end
		end
	end

	assign sts = '{kind: kind, out_free: (!out_valid_q || out_ready),
		run_done: (count_q == 6'd1)};

	assign wr_addr  = hash_of(px);
	assign rd_en    = cmd.take && (kind == KIND_INDEX);
	assign index_px = hit_q ? qrcd_pixel_t'(rd_data) : '0;

	qrcd_ram #(
		.WIDTH(24),
		.DEPTH(INDEX_DEPTH)
	) u_index (
		.clk     (clk),
		.wr_en   (cmd.take && wr),
		.wr_addr (wr_addr),
		.wr_data (px),
		.rd_en   (rd_en),
		.rd_addr (chunk_byte[INDEX_AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 2'd0;
			rgb_q   <= 1'b0;
			held_q  <= 16'd0;
			prev_q  <= '0;
			valid_q <= '0;
			hit_q   <= 1'b0;
			count_q <= 6'd0;
		end else begin
			if (cmd.take) begin
				pend_q <= pend_n;
				rgb_q  <= rgb_n;
				held_q <= held_n;
				if (wr) begin
					// A new image empties the table before its first pixel lands.
					valid_q <= (image_start ? '0 : valid_q) | (INDEX_DEPTH'(1) << wr_addr);
					prev_q  <= px;
				end else if (image_start) begin
					valid_q <= '0;
					prev_q  <= '0;
				end
				if (rd_en) begin
					hit_q <= valid_q[chunk_byte[INDEX_AW-1:0]] && !image_start;
				end
				count_q <= chunk_byte[5:0];
			end else if (cmd.index_load) begin
				prev_q <= index_px;
			end else if (cmd.run_step) begin
				count_q <= count_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((cmd.take && emit) || cmd.index_load || cmd.run_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && emit) begin
			out_pixel_q <= px;
			out_last_q  <= emit_last;
			out_bad_q   <= emit_bad;
		end else if (cmd.index_load) begin
			out_pixel_q <= index_px;
			out_last_q  <= 1'b1;
			out_bad_q   <= 1'b0;
		end else if (cmd.run_step) begin
			out_pixel_q <= prev_q;
			out_last_q  <= (count_q == 6'd1);
			out_bad_q   <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign out_last  = out_last_q;
	assign out_bad   = out_bad_q;

endmodule
`default_nettype wire

FILE: sv/qoi_rgb_chunk_decoder_core.sv
// Top level of the QOI RGB chunk decoder.
//
// The slave stream carries the QOI chunk bytes that follow the image header,
// one byte per transaction; s_tuser set on a byte starts a new image and
// clears the color index, the previous pixel and any partial chunk first.
// The master stream carries one decoded RGB pixel per transaction. m_tlast
// marks the last pixel caused by one input byte, and m_tuser flags an RGBA
// opcode, which is not decoded and gives one all-zero pixel.
// DIFF, LUMA, RGB and RGBA bytes need no state beyond ST_ACCEPT; a byte that completes
// a chunk has its pixel in the output register at the next clock edge.
// An INDEX byte also passes through ST_INDEX, for the registered read of the 64-entry
// color index RAM. A run holds the input in ST_RUN and gives its further pixels, one
// pixel per cycle through the single output register while the receiver takes them.
// When the receiver stalls, the pixel waits in the output register and
// s_tready falls until it is taken. Reset clears the valid bits of the
// color index at once, so the block accepts bytes right after reset.
`default_nettype none
module qoi_rgb_chunk_decoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] chunk_byte
	input  wire logic        s_tuser,   // [0] image_start
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	output      logic        m_tlast,   // run_last
	output      logic        m_tuser    // [0] bad_chunk
);
	import qrcd_pkg::*;

	qrcd_cmd_t   cmd;
	qrcd_sts_t   sts;
	qrcd_pixel_t out_pixel;

	qrcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	qrcd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.chunk_byte  (s_tdata),
		.image_start (s_tuser),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_pixel   (out_pixel),
		.out_last    (m_tlast),
		.out_bad     (m_tuser)
	);

	assign m_tdata = {out_pixel.b, out_pixel.g, out_pixel.r};

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for the QOI RGB chunk decoder: directed chunks, then random chunk streams.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qrcd_pkg::*;

	localparam int unsigned RANDOM_BYTES  = 420;
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned MAX_SHOWN     = 10;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned DIRECTED_ROWS = 24;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
		logic       bad;
	} pixel_out_t;

	typedef struct packed {
		logic [7:0] chunk;
		logic       start;
		logic       typed;
		pixel_out_t want;
	} stim_row_t;

	localparam pixel_out_t NO_PIXEL   = '0;
	localparam pixel_out_t BLACK_LAST = '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0};
	localparam pixel_out_t RGBA_FLAG  = '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	qoi_rgb_chunk_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// Decoder state as the stream has left it.
	logic [23:0]  color_tbl [INDEX_DEPTH];
	qrcd_pixel_t  last_px;
	logic [1:0]   bytes_owed;
	logic         owed_rgb;
	logic [15:0]  held;

	pixel_out_t   decoded[$];
	pixel_out_t   expected_px[$];

	int unsigned  cycle_count;
	int unsigned  fail_count;
	int unsigned  bytes_sent;
	int unsigned  pixels_checked;
	int unsigned  images;
	int unsigned  run_chunks;
	int unsigned  run_pixels;
	int unsigned  rgba_seen;
	int unsigned  next_gap;
	bit           send_burst;
	bit           recv_burst;
	bit           paused;

	// Extremes of every chunk kind, image start on partial chunks, RGBA handling.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{{TAG_INDEX, 6'd0},       1'b1, 1'b1, BLACK_LAST},
		'{OP_RGBA,                 1'b0, 1'b1, RGBA_FLAG},
		'{{TAG_DIFF, 6'b00_00_00}, 1'b0, 1'b0, NO_PIXEL},
		'{{TAG_DIFF, 6'b11_11_11}, 1'b0, 1'b0, NO_PIXEL},
		'{{TAG_DIFF, 6'b01_01_01}, 1'b0, 1'b0, NO_PIXEL},
		'{OP_RGB,                  1'b0, 1'b0, NO_PIXEL},
		'{8'hFF,                   1'b0, 1'b0, NO_PIXEL},
		'{8'h80,                   1'b0, 1'b0, NO_PIXEL},
		'{8'h01,                   1'b0, 1'b1, '{8'hFF, 8'h80, 8'h01, 1'b1, 1'b0}},
		'{{TAG_LUMA, 6'd0},        1'b0, 1'b0, NO_PIXEL},
		'{8'h00,                   1'b0, 1'b0, NO_PIXEL},
		'{{TAG_LUMA, 6'd63},       1'b0, 1'b0, NO_PIXEL},
		'{8'hFF,                   1'b0, 1'b0, NO_PIXEL},
		'{{TAG_RUN, 6'd0},         1'b0, 1'b0, NO_PIXEL},
		'{{TAG_RUN, 6'd61},        1'b0, 1'b0, NO_PIXEL},
		'{{TAG_INDEX, 6'd63},      1'b0, 1'b0, NO_PIXEL},
		'{{TAG_INDEX, 6'd42},      1'b0, 1'b0, NO_PIXEL},
		'{{TAG_LUMA, 6'd17},       1'b0, 1'b0, NO_PIXEL},
		'{{TAG_DIFF, 6'd0},        1'b1, 1'b1, '{8'hFE, 8'hFE, 8'hFE, 1'b1, 1'b0}},
		'{OP_RGB,                  1'b0, 1'b0, NO_PIXEL},
		'{8'h12,                   1'b0, 1'b0, NO_PIXEL},
		'{{TAG_INDEX, 6'd52},      1'b1, 1'b1, BLACK_LAST},
		'{OP_RGBA,                 1'b0, 1'b1, RGBA_FLAG},
		'{{TAG_RUN, 6'd5},         1'b1, 1'b0, NO_PIXEL}
	};

	function automatic logic [INDEX_AW-1:0] color_slot(input qrcd_pixel_t px);
		return INDEX_AW'(int'(px.r) * 3 + int'(px.g) * 5 + int'(px.b) * 7 + 255 * 11);
	endfunction

	function automatic void record_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		qrcd_pixel_t px;
		px = '{r: r, g: g, b: b};
		color_tbl[color_slot(px)] = px;
		last_px = px;
		decoded.push_back('{r, g, b, 1'b1, 1'b0});
	endfunction

	// Works out the pixels that one chunk byte produces, in order.
	function automatic void decode_chunk_byte(input logic [7:0] c, input logic st);
		logic [7:0] dg;
		int unsigned n;
		decoded.delete();
		if (st) begin
			foreach (color_tbl[i])
				color_tbl[i] = '0;
			last_px = '0;
			bytes_owed = '0;
			owed_rgb = 1'b0;
			held = '0;
			images++;
		end
		if (bytes_owed != 0) begin
			if (owed_rgb && bytes_owed > 1) begin
				held = {held[7:0], c};
				bytes_owed--;
			end else if (owed_rgb) begin
				bytes_owed = '0;
				record_pixel(held[15:8], held[7:0], c);
			end else begin
				// LUMA: red and blue deltas are relative to the green delta.
				dg = {2'b00, held[5:0]} - 8'd32;
				bytes_owed = '0;
				record_pixel(last_px.r + dg + {4'h0, c[7:4]} - 8'd8, last_px.g + dg,
					last_px.b + dg + {4'h0, c[3:0]} - 8'd8);
			end
		end else if (c[7:6] == TAG_INDEX) begin
			last_px = color_tbl[c[5:0]];
			decoded.push_back('{last_px.r, last_px.g, last_px.b, 1'b1, 1'b0});
		end else if (c[7:6] == TAG_DIFF) begin
			record_pixel(last_px.r + {6'h00, c[5:4]} - 8'd2,
				last_px.g + {6'h00, c[3:2]} - 8'd2,
				last_px.b + {6'h00, c[1:0]} - 8'd2);
		end else if (c[7:6] == TAG_LUMA) begin
			held = {8'h00, c};
			owed_rgb = 1'b0;
			bytes_owed = 2'd1;
		end else if (c == OP_RGB) begin
			held = '0;
			owed_rgb = 1'b1;
			bytes_owed = RGB_DATA_BYTES;
		end else if (c == OP_RGBA) begin
			decoded.push_back(RGBA_FLAG);
			rgba_seen++;
		end else begin
			n = c[5:0] + 1;
			for (int unsigned k = 0; k < n; k++)
				decoded.push_back('{last_px.r, last_px.g, last_px.b, k == n - 1, 1'b0});
			run_chunks++;
			run_pixels += n;
		end
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic st, input logic typed = 1'b0,
			input pixel_out_t want = '0);
		repeat (next_gap) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tuser <= st;
		do @(posedge clk); while (!s_tready);
		decode_chunk_byte(c, st);
		if (typed)
			expected_px.push_back(want);
		else
			foreach (decoded[i])
				expected_px.push_back(decoded[i]);
		bytes_sent++;
		if ($urandom_range(0, 29) == 0)
			send_burst = !send_burst;
		next_gap = send_burst ? 0 : $urandom_range(0, 10);
		// Valid stays up only when the next byte follows at once.
		if (next_gap != 0)
			s_tvalid <= 1'b0;
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_px.size() != 0);
	endtask

	// Mostly well-formed chunks with random content; some noise and stray image starts.
	task automatic send_random_chunk();
		int unsigned pick;
		int unsigned len;
		logic st;
		pick = $urandom_range(0, 99);
		st = ($urandom_range(0, 29) == 0);
		if (pick < 20) begin
			send_byte({TAG_INDEX, 6'($urandom)}, st);
		end else if (pick < 40) begin
			send_byte({TAG_DIFF, 6'($urandom)}, st);
		end else if (pick < 60) begin
			send_byte({TAG_LUMA, 6'($urandom)}, st);
			send_byte(8'($urandom), $urandom_range(0, 99) == 0);
		end else if (pick < 75) begin
			send_byte(OP_RGB, st);
			repeat (RGB_DATA_BYTES)
				send_byte(8'($urandom), $urandom_range(0, 99) == 0);
		end else if (pick < 90) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 62) : $urandom_range(1, 8);
			send_byte({TAG_RUN, 6'(len - 1)}, st);
		end else if (pick < 94) begin
			send_byte(OP_RGBA, st);
		end else begin
			send_byte(8'($urandom), st);
		end
	endtask

	function automatic void report_mismatch(input string what, input pixel_out_t want,
			input pixel_out_t got);
		fail_count++;
		if (fail_count <= MAX_SHOWN)
			$display("%t %s: expected r=%h g=%h b=%h last=%b bad=%b, got r=%h g=%h b=%h last=%b bad=%b",
				$time, what, want.red, want.green, want.blue, want.last, want.bad,
				got.red, got.green, got.blue, got.last, got.bad);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d pixels still expected", cycle_count,
				expected_px.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Pixel receiver: random stalls, then each transaction is checked in order.
	initial begin
		int unsigned stall;
		pixel_out_t got;
		pixel_out_t want;
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				recv_burst = !recv_burst;
			stall = recv_burst ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast, m_tuser};
			if (expected_px.size() == 0) begin
				report_mismatch("pixel with none expected", NO_PIXEL, got);
			end else begin
				want = expected_px.pop_front();
				if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
						got.last !== want.last || got.bad !== want.bad)
					report_mismatch("pixel mismatch", want, got);
			end
			pixels_checked++;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_byte(directed_rows[i].chunk, directed_rows[i].start, directed_rows[i].typed,
				directed_rows[i].want);
		hold_until_drained();
		while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES) begin
			if (!paused && bytes_sent >= DIRECTED_ROWS + RANDOM_BYTES / 2) begin
				hold_until_drained();
				paused = 1'b1;
			end
			send_random_chunk();
		end
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d chunk bytes across %0d image starts; checked %0d pixels.",
			bytes_sent, images, pixels_checked);
		$display("Runs: %0d chunks giving %0d pixels; RGBA opcodes flagged: %0d; failures: %0d.",
			run_chunks, run_pixels, rgba_seen, fail_count);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
